[rtl/core/adrp_pkg.sv]
package adrp_pkg;

    // Instruction encodings
    localparam logic [31:0] AdrpMask  = 32'h9F00_0000;
    localparam logic [31:0] AdrpCode  = 32'h9000_0000;
    localparam logic [31:0] AddxMask  = 32'hFFC0_0000;
    localparam logic [31:0] AddxCode  = 32'h9100_0000;
    localparam logic [4:0]  RegZrSp   = 5'h1F;

    localparam int unsigned AddrW     = 64;
    localparam int unsigned PageW     = AddrW - 12;
    localparam int unsigned CfgIndexW = 8;
    localparam logic [AddrW-1:0] InstrStep = 64'd4;

    // Configuration register indexes
    typedef enum logic [CfgIndexW-1:0] {
        CFG_SECTION_BASE   = 8'd0,
        CFG_TARGET_ADDRESS = 8'd1
    } cfg_index_t;

    typedef struct packed {
        logic [31:0] instr_word;
        logic        restart;
    } in_item_t;

    typedef struct packed {
        logic             hit;
        logic [AddrW-1:0] hit_address;
        logic             found;
    } out_item_t;

    typedef struct packed {
        logic [AddrW-1:0] section_base;
        logic [AddrW-1:0] target_address;
    } cfg_regs_t;

endpackage

[rtl/core/adrp_add_xref_scanner.sv]
// ADRP/ADD reference scanner. Takes one AArch64 instruction word per cycle
// (s_ channel) and returns one result per word (m_ channel) reporting
// whether this word, as an ADD-immediate, completes the first ADRP/ADD pair
// of the scan that forms target_address, with the ADRP's address. Set
// restart on the first word of a scan; that word sits at section_base.
// Words before any restart are counted from address 0. Throughput is one
// word per cycle, held back only by m_ready. Write the two address
// registers through the cfg_ port (index 0 section_base, index 1
// target_address) while idle.
module adrp_add_xref_scanner (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [adrp_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [adrp_pkg::AddrW-1:0]     cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  adrp_pkg::in_item_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output adrp_pkg::out_item_t            m_data
);
    import adrp_pkg::*;

    cfg_regs_t        cfg;

    logic             in_valid_reg;
    in_item_t         in_data_reg;
    logic             out_valid_reg;
    out_item_t        out_data_reg;
    out_item_t        out_data_next;

    logic [31:0]      prev_word_reg;
    logic             prev_valid_reg;
    logic [AddrW-1:0] prev_addr_reg;
    logic [AddrW-1:0] cur_addr_reg;
    logic             match_seen_reg;

    logic             advance;
    logic [AddrW-1:0] addr;
    logic             pair_hit;
    logic             hit;

    adrp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    adrp_pair_match u_match (
        .first_word     (prev_word_reg),
        .second_word    (in_data_reg.instr_word),
        .first_address  (prev_addr_reg),
        .target_address (cfg.target_address),
        .match          (pair_hit)
    );

    // Handshake: result register frees up when empty or taken
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Scan step for the word in the input register
    assign addr = in_data_reg.restart ? cfg.section_base : cur_addr_reg;
    assign hit  = pair_hit && !in_data_reg.restart && prev_valid_reg && !match_seen_reg;

    always_comb begin
        out_data_next.hit         = hit;
        out_data_next.hit_address = hit ? prev_addr_reg : '0;
        out_data_next.found       = hit || (match_seen_reg && !in_data_reg.restart);
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Scan state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            prev_word_reg  <= '0;
            prev_valid_reg <= 1'b0;
            prev_addr_reg  <= '0;
            cur_addr_reg   <= '0;
            match_seen_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                prev_word_reg  <= in_data_reg.instr_word;
                prev_valid_reg <= 1'b1;
                prev_addr_reg  <= addr;
                cur_addr_reg   <= addr + InstrStep;
                match_seen_reg <= out_data_next.found;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

[rtl/core/adrp_cfg_regs.sv]
module adrp_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [adrp_pkg::CfgIndexW-1:0]     cfg_index,
    input  logic [adrp_pkg::AddrW-1:0]         cfg_data,
    output adrp_pkg::cfg_regs_t                cfg
);
    import adrp_pkg::*;

    cfg_regs_t cfg_reg;
    cfg_regs_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg          = cfg_reg;

    // Register write decode; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                CFG_SECTION_BASE:   cfg_next.section_base   = cfg_data;
                CFG_TARGET_ADDRESS: cfg_next.target_address = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/core/adrp_pair_match.sv]
module adrp_pair_match (
    input  logic [31:0]                first_word,
    input  logic [31:0]                second_word,
    input  logic [adrp_pkg::AddrW-1:0] first_address,
    input  logic [adrp_pkg::AddrW-1:0] target_address,
    output logic                       match
);
    import adrp_pkg::*;

    logic             is_adrp;
    logic             is_addx;
    logic [4:0]       rd;
    logic [4:0]       rn;
    logic [20:0]      imm21;
    logic [PageW-1:0] page;
    logic [11:0]      imm12;

    // Decode both words
    assign is_adrp = (first_word & AdrpMask) == AdrpCode;
    assign is_addx = (second_word & AddxMask) == AddxCode;
    assign rd      = first_word[4:0];
    assign rn      = second_word[9:5];
    assign imm21   = {first_word[23:5], first_word[30:29]};
    assign imm12   = second_word[21:10];

    // Page sum: the low 12 bits of page and offset never overlap, so no carry
    assign page = first_address[AddrW-1:12] + {{(PageW-21){imm21[20]}}, imm21};

    assign match = is_adrp && is_addx && (rd == rn) && (rd != RegZrSp)
                   && ({page, imm12} == target_address);

endmodule

[rtl/core/adrp_checker.sv]
module adrp_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input adrp_pkg::out_item_t m_data
);
    import adrp_pkg::*;

    // A hit always marks the scan as found
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.hit |-> m_data.found)
        else $error("hit without found");

    // Address is zero unless this result is a hit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.hit |-> m_data.hit_address == '0)
        else $error("hit_address set without hit");

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // No result straight out of reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind adrp_add_xref_scanner adrp_checker u_adrp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[dv/adrp_scan_checker.sv]
// Watches the config, word and result channels, keeps its own copy of the
// scanner state and checks every result transfer against the oldest
// prediction still waiting.
module adrp_scan_checker
    import adrp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [AddrW-1:0]     cfg_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  in_item_t             s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  out_item_t            m_data,
    output int                   fail_count,
    output int                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ReportLimit = 10;

    // shadow of the scanner's registers and state
    logic [AddrW-1:0] sec_base;
    logic [AddrW-1:0] tgt_addr;
    logic [31:0]      last_word;
    logic             last_valid;
    logic [AddrW-1:0] scan_pc;
    logic             match_done;

    out_item_t        scan_expect[$];
    out_item_t        want;

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    // does the ADRP at pc plus the following ADD form the target address
    function automatic logic pair_hits(logic [31:0] first, logic [31:0] second,
                                       logic [AddrW-1:0] pc);
        logic [4:0]       rd;
        logic [4:0]       rn;
        logic [AddrW-1:0] imm;
        logic [AddrW-1:0] page;
        rd  = first[4:0];
        rn  = second[9:5];
        imm = {41'b0, first[25:5], first[30:29]};
        if (imm[20]) begin
            imm |= ~64'h1F_FFFF;
        end
        page = (pc & ~64'hFFF) + (imm << 12);
        return ((first & AdrpMask) == AdrpCode) && ((second & AddxMask) == AddxCode) &&
               (rd == rn) && (rd != RegZrSp) &&
               (page + {52'b0, second[21:10]} == tgt_addr);
    endfunction

    // advance the shadow state by one word and return the result it gives
    function automatic out_item_t scan_word(in_item_t item);
        out_item_t        res;
        logic [AddrW-1:0] word_pc;
        logic [AddrW-1:0] adrp_pc;
        res = '0;
        if (item.restart) begin
            scan_pc    = sec_base;
            last_valid = 1'b0;
            match_done = 1'b0;
        end
        word_pc = scan_pc;
        adrp_pc = word_pc - InstrStep;
        if (last_valid && !match_done && pair_hits(last_word, item.instr_word, adrp_pc)) begin
            res.hit         = 1'b1;
            res.hit_address = adrp_pc;
            match_done      = 1'b1;
        end
        last_word  = item.instr_word;
        last_valid = 1'b1;
        scan_pc    = word_pc + InstrStep;
        res.found  = match_done;
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            sec_base   = '0;
            tgt_addr   = '0;
            last_word  = '0;
            last_valid = 1'b0;
            scan_pc    = '0;
            match_done = 1'b0;
            scan_expect.delete();
        end else begin
            // register writes; unknown indexes are dropped
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SECTION_BASE: begin
                        sec_base = cfg_data;
                    end
                    CFG_TARGET_ADDRESS: begin
                        tgt_addr = cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            // result transfer: compare against the oldest prediction
            if (m_valid && m_ready) begin
                if (scan_expect.size() == 0) begin
                    fail_count++;
                    if (fail_count <= ReportLimit) begin
                        $display("%0t: result with nothing pending: hit=%b addr=%h found=%b",
                                 $realtime, m_data.hit, m_data.hit_address, m_data.found);
                    end
                end else begin
                    want = scan_expect.pop_front();
                    if (m_data.hit !== want.hit || m_data.hit_address !== want.hit_address ||
                        m_data.found !== want.found) begin
                        fail_count++;
                        if (fail_count <= ReportLimit) begin
                            $display("%0t: exp hit=%b addr=%h found=%b, got hit=%b addr=%h found=%b",
                                     $realtime, want.hit, want.hit_address, want.found,
                                     m_data.hit, m_data.hit_address, m_data.found);
                        end
                    end
                end
            end
            // word transfer: predict its result
            if (s_valid && s_ready) begin
                scan_expect.push_back(scan_word(s_data));
            end
        end
        outstanding <= scan_expect.size();
    end

endmodule

[dv/tb_top.sv]
module tb_top
    import adrp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ClkHalf       = 5;
    localparam int          ResetCycles   = 5;
    localparam int          RxHoldCycles  = 300;
    localparam int          CycleLimit    = 200_000;
    localparam int          DrainCycles   = 8;
    localparam int          PhaseWords    = 170;
    localparam int          NumPhases     = 4;
    localparam logic [31:0] AddShiftBit   = 32'h0040_0000;
    localparam logic [31:0] AddSfBit      = 32'h8000_0000;

    // flavours of ADRP/ADD pair sent to the block
    typedef enum int {
        PAIR_GOOD,
        PAIR_WRONG_REG,
        PAIR_SHIFTED,
        PAIR_OFF_BY_ONE,
        PAIR_NARROW,
        PAIR_ZR
    } pair_kind_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CfgIndexW-1:0] cfg_index = '0;
    logic [AddrW-1:0]     cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_data;

    int                   fail_count;
    int                   outstanding;
    int                   cycle_count  = 0;
    int                   tx_idle_pct  = 0;
    int                   rx_stall_pct = 0;
    logic                 hold_token   = 1'b0;
    logic                 hold_seen    = 1'b0;
    int                   hold_left    = 0;

    // stimulus-side view of the scan position
    logic [AddrW-1:0]     next_pc    = '0;
    logic [AddrW-1:0]     cur_base   = '0;
    logic [AddrW-1:0]     cur_target = '0;
    int                   words_sent = 0;

    adrp_add_xref_scanner DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    adrp_scan_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always begin
        aclk = 1'b0;
        #ClkHalf;
        aclk = 1'b1;
        #ClkHalf;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off on each token flip
    always @(posedge aclk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= RxHoldCycles;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ADRP at pc whose page holds dest
    function automatic logic [31:0] adrp_word(logic [AddrW-1:0] pc, logic [AddrW-1:0] dest,
                                              logic [4:0] rd);
        logic [PageW-1:0] delta;
        delta = dest[AddrW-1:12] - pc[AddrW-1:12];
        return AdrpCode | {1'b0, delta[1:0], 5'b0, delta[20:2], rd};
    endfunction

    // 64-bit unshifted ADD immediate reading rn, adding the page offset of dest
    function automatic logic [31:0] add_word(logic [AddrW-1:0] dest, logic [4:0] rn);
        return AddxCode | {10'b0, dest[11:0], rn, 5'($urandom_range(31))};
    endfunction

    // one word transfer, with random idle cycles ahead of it
    task automatic put_word(logic [31:0] word, logic rs);
        in_item_t item;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        if (rs) begin
            next_pc = cur_base;
        end
        item.instr_word = word;
        item.restart    = rs;
        s_data  <= item;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        next_pc += InstrStep;
        words_sent++;
    endtask

    // ADRP followed by an ADD, correct or spoilt in one way
    task automatic emit_pair(logic rs, pair_kind_t kind);
        logic [4:0]  rd;
        logic [31:0] add;
        if (rs) begin
            next_pc = cur_base;
        end
        rd  = (kind == PAIR_ZR) ? RegZrSp : 5'($urandom_range(30));
        add = add_word(cur_target, rd);
        case (kind)
            PAIR_WRONG_REG: begin
                add = add_word(cur_target, rd ^ 5'(1 << $urandom_range(4)));
            end
            PAIR_SHIFTED: begin
                add |= AddShiftBit;
            end
            PAIR_OFF_BY_ONE: begin
                add = add_word(cur_target + 1, rd);
            end
            PAIR_NARROW: begin
                add &= ~AddSfBit;
            end
            default: begin
            end
        endcase
        put_word(adrp_word(next_pc, cur_target, rd), rs);
        put_word(add, 1'b0);
    endtask

    // stop offering words and wait for every predicted result
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // valid stays up so writes can follow back to back; the caller drops it
    task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [AddrW-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // new base and target while idle, plus a write to an unused index
    task automatic set_scan(logic [AddrW-1:0] base, logic [AddrW-1:0] target);
        wait_drained();
        write_reg(CFG_SECTION_BASE, base);
        write_reg(CFG_TARGET_ADDRESS, target);
        write_reg(CfgIndexW'($urandom_range(2 ** CfgIndexW - 1, CFG_TARGET_ADDRESS + 1)),
                  {$urandom, $urandom});
        cfg_valid <= 1'b0;
        cur_base   = base;
        cur_target = target;
    endtask

    initial begin
        logic [AddrW-1:0] base;
        logic [AddrW-1:0] target;
        logic [31:0]      offs;
        int               phase_start;
        int               pick;
        logic             rs;
        logic             pressure_done;

        repeat (ResetCycles) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // no restart yet: addresses count from zero, registers at reset values
        emit_pair(1'b0, PAIR_GOOD);
        emit_pair(1'b0, PAIR_GOOD);       // later match is suppressed
        put_word('0, 1'b0);
        put_word('1, 1'b0);

        // target reached only through address wrap
        set_scan(64'hFFFF_FFFF_FFFF_F000, 64'h0000_0000_0000_1234);
        emit_pair(1'b1, PAIR_ZR);
        emit_pair(1'b0, PAIR_SHIFTED);
        emit_pair(1'b0, PAIR_NARROW);
        emit_pair(1'b0, PAIR_WRONG_REG);
        emit_pair(1'b0, PAIR_OFF_BY_ONE);
        emit_pair(1'b0, PAIR_GOOD);
        // ADRP closes one scan, the matching ADD opens the next
        put_word(adrp_word(next_pc, cur_target, 5'd9), 1'b0);
        put_word(add_word(cur_target, 5'd9), 1'b1);

        // random phases, each with its own registers and idling mix
        for (int ph = 0; ph < NumPhases; ph++) begin
            offs = $urandom;
            case (ph)
                0: begin
                    base   = '0;
                    target = '1;
                    tx_idle_pct   = 0;
                    rx_stall_pct <= 0;
                end
                1: begin
                    base   = '1;
                    target = base + {{32{offs[31]}}, offs};
                    tx_idle_pct   = 55;
                    rx_stall_pct <= 0;
                end
                2: begin
                    base   = {$urandom, $urandom} & ~64'h3;
                    target = base + {{32{offs[31]}}, offs};
                    tx_idle_pct   = 0;
                    rx_stall_pct <= 55;
                end
                default: begin
                    base   = {$urandom, $urandom};
                    target = base + {{32{offs[31]}}, offs};
                    tx_idle_pct   = 28;
                    rx_stall_pct <= 28;
                end
            endcase
            set_scan(base, target);
            phase_start   = words_sent;
            pressure_done = 1'b0;
            while (words_sent - phase_start < PhaseWords) begin
                // long receiver hold-off while words keep coming
                if (ph == 0 && !pressure_done && words_sent - phase_start >= 40) begin
                    hold_token    <= ~hold_token;
                    pressure_done  = 1'b1;
                end
                // sender pause until the block has emptied
                if (ph == 1 && !pressure_done && words_sent - phase_start >= 80) begin
                    wait_drained();
                    pressure_done = 1'b1;
                end
                pick = $urandom_range(99);
                rs   = ($urandom_range(7) == 0);
                if (pick < 55) begin
                    emit_pair(rs, PAIR_GOOD);
                end else if (pick < 72) begin
                    emit_pair(rs, pair_kind_t'($urandom_range(PAIR_ZR, PAIR_WRONG_REG)));
                end else begin
                    put_word($urandom, rs);
                end
            end
        end

        wait_drained();
        repeat (DrainCycles) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
